### rtl/hrp_pkg.sv
// Shared types and constants for the H.263+ RTP packetizer.
`default_nettype none
package hrp_pkg;

   localparam int LEN_BITS  = 16;
   localparam int FILL_BITS = 17;
   localparam int SUM_BITS  = ((LEN_BITS > 16) ? LEN_BITS : 16) + 1;
   localparam int CSR_BITS  = 17;
   localparam int IDX_BITS  = 2;

   localparam logic [15:0] MIN_PAYLOAD   = 16'd128;
   localparam logic [15:0] RST_MAX_PAY   = 16'd1400;
   localparam logic [16:0] RST_TS_STEP   = 17'd3000;
   localparam logic [6:0]  RST_PAY_KIND  = 7'd96;
   localparam logic [7:0]  FIRST_HDR     = 8'h04;
   localparam logic [7:0]  ZERO_HDR      = 8'h00;

   localparam logic [IDX_BITS-1:0] CSR_MAX_PAYLOAD = 2'd0;
   localparam logic [IDX_BITS-1:0] CSR_TS_STEP     = 2'd1;
   localparam logic [IDX_BITS-1:0] CSR_PAY_KIND    = 2'd2;

   typedef struct packed {
      logic [7:0]          data_byte;
      logic [LEN_BITS-1:0] frame_bytes;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        packet_start;
      logic        packet_end;
      logic        marker;
      logic [16:0] ts_increment;
      logic [6:0]  payload_type;
      logic        run_last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] max_payload;
      logic [16:0] timestamp_step;
      logic [6:0]  payload_kind;
   } cfg_type;

   // up to three beats produced by one input byte; beat[0] goes out first
   typedef struct packed {
      rsp_type [2:0] beat;
      logic [1:0]    count;
   } burst_type;

endpackage
`default_nettype wire

### rtl/h263_rtp_packetizer.sv
// Top level of the H.263+ (RFC 4629) RTP payload packetizer.
// Frame bytes enter on req_ (valid/ready), one beat per byte, each beat
// carrying the frame's total length. Payload bytes leave on rsp_, one beat
// per byte, flagged with packet start/end, marker, timestamp step, payload
// type and run_last on the final beat caused by each input byte.
// csr_ writes set max_payload, timestamp_step and payload_kind; write them
// only while no frame byte is in flight.
// A byte is registered at the input, then framed and loaded into the
// result register, from which its first result beat is presented.
// Throughput: one input byte per cycle while rsp_ready is high; a byte that
// opens a later packet yields three beats (two header bytes plus data) and
// holds the input until they drain through the single-beat output port.
// While rsp_ready is low the result register holds its beats and the input
// register still takes one more byte before req_ready drops.
// Reset clears all framing state and restores the register defaults
// (1400, 3000, 96); the next byte is taken as the start of a frame.
`default_nettype none
module h263_rtp_packetizer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire hrp_pkg::req_type             req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output hrp_pkg::rsp_type                  rsp_data,
   input  wire logic                         csr_we,
   input  wire logic [hrp_pkg::IDX_BITS-1:0] csr_index,
   input  wire logic [hrp_pkg::CSR_BITS-1:0] csr_wdata
);

   hrp_pkg::cfg_type   cfg_ff, cfg_in;
   hrp_pkg::req_type   item_ff;
   logic               item_valid_ff, item_valid_in;
   logic               buf_free, advance;
   hrp_pkg::burst_type burst;

   assign advance   = item_valid_ff && buf_free;
   assign req_ready = !item_valid_ff || advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            hrp_pkg::CSR_MAX_PAYLOAD: cfg_in.max_payload    = csr_wdata[15:0];
            hrp_pkg::CSR_TS_STEP:     cfg_in.timestamp_step = csr_wdata[16:0];
            hrp_pkg::CSR_PAY_KIND:    cfg_in.payload_kind   = csr_wdata[6:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
      item_valid_in = item_valid_ff;
      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_payload    <= hrp_pkg::RST_MAX_PAY;
         cfg_ff.timestamp_step <= hrp_pkg::RST_TS_STEP;
         cfg_ff.payload_kind   <= hrp_pkg::RST_PAY_KIND;
         item_valid_ff         <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   hrp_pkt_logic u_pkt_logic (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .burst   (burst)
   );

   hrp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .burst     (burst),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### rtl/hrp_pkt_logic.sv
// Packet framing state and per-byte beat generation.
`default_nettype none
module hrp_pkt_logic (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire hrp_pkg::req_type   item,
   input  wire hrp_pkg::cfg_type   cfg,
   output hrp_pkg::burst_type      burst
);

   logic [hrp_pkg::LEN_BITS-1:0]  off_ff, off_in, off_inc;
   logic [hrp_pkg::FILL_BITS-1:0] fill_ff, fill_in, fill_sum;
   logic                          first_ff, first_in;
   logic                          final_ff, final_in, final_now;
   logic [15:0]                   mp;
   logic [hrp_pkg::SUM_BITS-1:0]  fb_ext, mp_ext, reach;
   logic                          opening, open_later, frame_done, pkt_done;
   logic [7:0]                    byte0;
   hrp_pkg::rsp_type              common;

   always_comb begin
      mp = (cfg.max_payload < hrp_pkg::MIN_PAYLOAD) ? hrp_pkg::MIN_PAYLOAD
                                                    : cfg.max_payload;
      fb_ext = hrp_pkg::SUM_BITS'(item.frame_bytes);
      mp_ext = hrp_pkg::SUM_BITS'(mp);
      reach  = hrp_pkg::SUM_BITS'(off_ff) + mp_ext - hrp_pkg::SUM_BITS'(2);
      opening    = (fill_ff == '0);
      open_later = opening && !first_ff;

      // final decision is made when a packet opens and held for it
      final_now = final_ff;
      if (opening && first_ff) begin
         final_now = (fb_ext <= mp_ext);
      end else if (open_later) begin
         final_now = (reach >= fb_ext);
      end

      if (opening && first_ff) begin
         byte0 = hrp_pkg::FIRST_HDR;
      end else if (open_later) begin
         byte0 = hrp_pkg::ZERO_HDR;
      end else if (first_ff && off_ff == hrp_pkg::LEN_BITS'(1)) begin
         // second start-code byte becomes the zero header byte
         byte0 = hrp_pkg::ZERO_HDR;
      end else begin
         byte0 = item.data_byte;
      end

      fill_sum   = fill_ff + (open_later ? hrp_pkg::FILL_BITS'(3)
                                         : hrp_pkg::FILL_BITS'(1));
      off_inc    = off_ff + hrp_pkg::LEN_BITS'(1);
      frame_done = (off_inc >= item.frame_bytes) || (off_inc == '0);
      pkt_done   = frame_done || (fill_sum >= hrp_pkg::FILL_BITS'(mp));

      common.out_byte     = item.data_byte;
      common.packet_start = 1'b0;
      common.packet_end   = 1'b0;
      common.marker       = final_now;
      common.ts_increment = final_now ? cfg.timestamp_step : 17'd0;
      common.payload_type = cfg.payload_kind;
      common.run_last     = 1'b0;

      burst.beat[0] = common;
      burst.beat[0].out_byte     = byte0;
      burst.beat[0].packet_start = opening;
      burst.beat[1] = common;
      burst.beat[1].out_byte     = hrp_pkg::ZERO_HDR;
      burst.beat[2] = common;
      if (open_later) begin
         burst.count = 2'd3;
         burst.beat[2].packet_end = pkt_done;
         burst.beat[2].run_last   = 1'b1;
      end else begin
         burst.count = 2'd1;
         burst.beat[0].packet_end = pkt_done;
         burst.beat[0].run_last   = 1'b1;
      end

      off_in   = off_ff;
      fill_in  = fill_ff;
      first_in = first_ff;
      final_in = final_ff;
      if (advance) begin
         if (frame_done) begin
            off_in   = '0;
            fill_in  = '0;
            first_in = 1'b1;
            final_in = 1'b0;
         end else if (pkt_done) begin
            off_in   = off_inc;
            fill_in  = '0;
            first_in = 1'b0;
            final_in = final_now;
         end else begin
            off_in   = off_inc;
            fill_in  = fill_sum;
            final_in = final_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff   <= '0;
         fill_ff  <= '0;
         first_ff <= 1'b1;
         final_ff <= 1'b0;
      end else begin
         off_ff   <= off_in;
         fill_ff  <= fill_in;
         first_ff <= first_in;
         final_ff <= final_in;
      end
   end

endmodule
`default_nettype wire

### rtl/hrp_out_buf.sv
// Result register holding up to three beats, shifted out one per handshake.
`default_nettype none
module hrp_out_buf (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire hrp_pkg::burst_type burst,
   output logic                    free,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output hrp_pkg::rsp_type        rsp_data
);

   hrp_pkg::rsp_type [2:0] beat_ff, beat_in;
   logic [1:0]             cnt_ff, cnt_in;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = beat_ff[0];
   // refill as the last pending beat leaves
   assign free = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ready);

   always_comb begin
      beat_in = beat_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         beat_in = burst.beat;
         cnt_in  = burst.count;
      end else if (rsp_valid && rsp_ready) begin
         beat_in[0] = beat_ff[1];
         beat_in[1] = beat_ff[2];
         cnt_in     = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

endmodule
`default_nettype wire
